// ===== sv/ctf_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ctf_pkg
// shared types, constants and helpers of the complementary tilt filter
// ---------------------------------------------------------------------------
package ctf_pkg;

   localparam int unsigned ATAN_LEN   = 24;
   localparam int unsigned ACC_W      = 52;   // serial product accumulator
   localparam int unsigned MCAND_W    = 34;   // multiplicand width
   localparam int unsigned CRD_W      = 27;   // cordic x, y and z width
   localparam int unsigned KEEP_W     = 17;
   localparam logic [KEEP_W-1:0] KEEP_ONE = 17'd65536;
   localparam logic signed [CRD_W-1:0] DEG180 = 27'sd11796480;

   localparam logic [1:0] CSR_CHANGE_THR = 2'd0;
   localparam logic [1:0] CSR_GATE_THR   = 2'd1;
   localparam logic [1:0] CSR_GYRO_GAIN  = 2'd2;
   localparam logic [1:0] CSR_BLEND_KEEP = 2'd3;

   typedef enum logic {
      T_IDLE,
      T_RUN
   } ctf_top_state_type;

   typedef enum logic [1:0] {
      AX_IDLE,
      AX_MUL_RATE,
      AX_CORDIC,
      AX_MUL_BLEND
   } ctf_ax_state_type;

   typedef struct packed {
      logic start;
      logic corr;
   } ctf_axis_ctl_type;

   // atan(2^-i) in q16 degrees
   function automatic logic [21:0] ctf_atan(input logic [4:0] i);
      logic [21:0] r;
      unique case (i)
         5'd0:  r = 22'd2949120;
         5'd1:  r = 22'd1740967;
         5'd2:  r = 22'd919879;
         5'd3:  r = 22'd466945;
         5'd4:  r = 22'd234379;
         5'd5:  r = 22'd117304;
         5'd6:  r = 22'd58666;
         5'd7:  r = 22'd29335;
         5'd8:  r = 22'd14668;
         5'd9:  r = 22'd7334;
         5'd10: r = 22'd3667;
         5'd11: r = 22'd1833;
         5'd12: r = 22'd917;
         5'd13: r = 22'd458;
         5'd14: r = 22'd229;
         5'd15: r = 22'd115;
         5'd16: r = 22'd57;
         5'd17: r = 22'd29;
         5'd18: r = 22'd14;
         5'd19: r = 22'd7;
         5'd20: r = 22'd4;
         5'd21: r = 22'd2;
         5'd22: r = 22'd1;
         default: r = 22'd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] ctf_sat32(input logic signed [ACC_W-1:0] v);
      logic signed [31:0] r;
      if (v > 52'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -52'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== sv/ctf_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ctf request and response channels
// valid/ready channels carrying one sample word and one result word
// ---------------------------------------------------------------------------
interface ctf_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   logic signed [15:0] rate_x;
   logic signed [15:0] rate_y;
   modport source(output valid, accel_x, accel_y, accel_z, rate_x, rate_y,
                  input ready);
   modport sink(input valid, accel_x, accel_y, accel_z, rate_x, rate_y,
                output ready);
endinterface

interface ctf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] roll_angle;
   logic signed [31:0] pitch_angle;
   logic               moved_x;
   logic               moved_y;
   logic               moved_z;
   logic               corrected;
   modport source(output valid, roll_angle, pitch_angle, moved_x, moved_y, moved_z,
                  corrected, input ready);
   modport sink(input valid, roll_angle, pitch_angle, moved_x, moved_y, moved_z,
                corrected, output ready);
endinterface

// ===== sv/imu_complementary_tilt_filter.sv =====
`timescale 1ns / 1ps
// a word is accepted, then each axis runs its gyro multiply and, with
//   correction, its cordic and its blend multiply; the cordic is skipped
//   when both atan2 operands are zero
// a new word is accepted only once the result is loaded; the pace is set by
//   each axis unit's bit-serial 17-bit multiplies and one-step-per-cycle cordic
// reset: synchronous, clears angles and previous sample, loads the csr defaults
// ---------------------------------------------------------------------------
// imu_complementary_tilt_filter
// roll/pitch complementary filter with motion flags and gated accel blend
// ---------------------------------------------------------------------------
module imu_complementary_tilt_filter #(
   parameter int unsigned CORDIC_STEPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   ctf_req_if.sink     req_bus,
   ctf_rsp_if.source   rsp_bus,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [17:0] csr_wdata
);
   import ctf_pkg::*;

   ctf_top_state_type   state_ff, state_in;
   logic [15:0]         change_thr_ff, gyro_gain_ff;
   logic [17:0]         gate_thr_ff;
   logic [KEEP_W-1:0]   blend_keep_ff, keep_eff;
   logic signed [15:0]  prev_x_ff, prev_y_ff, prev_z_ff;
   logic [2:0]          moved_ff, moved_in;
   logic                corr_ff, corr_in;
   logic                out_valid_ff, out_valid_in;
   logic signed [31:0]  roll_out_ff, pitch_out_ff;
   logic [3:0]          flags_out_ff;
   logic                accept, load_out;
   logic [16:0]         dx, dy, dz;
   logic [17:0]         dsum;
   logic                roll_busy, pitch_busy;
   logic signed [31:0]  roll_w, pitch_w;
   ctf_axis_ctl_type    axis_ctl;

   function automatic logic [16:0] absdiff(input logic signed [15:0] a,
                                           input logic signed [15:0] b);
      logic signed [16:0] d;
      d = 17'(a) - 17'(b);
      return d[16] ? 17'(-d) : 17'(d);
   endfunction

   assign dx   = absdiff(req_bus.accel_x, prev_x_ff);
   assign dy   = absdiff(req_bus.accel_y, prev_y_ff);
   assign dz   = absdiff(req_bus.accel_z, prev_z_ff);
   assign dsum = 18'(dx) + 18'(dy) + 18'(dz);
   assign keep_eff = (blend_keep_ff > KEEP_ONE) ? KEEP_ONE : blend_keep_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= T_IDLE;
         out_valid_ff  <= 1'b0;
         change_thr_ff <= 16'd1229;
         gate_thr_ff   <= 18'd3277;
         gyro_gain_ff  <= 16'd10;
         blend_keep_ff <= 17'd64225;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         prev_z_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_CHANGE_THR: change_thr_ff <= csr_wdata[15:0];
               CSR_GATE_THR:   gate_thr_ff   <= csr_wdata;
               CSR_GYRO_GAIN:  gyro_gain_ff  <= csr_wdata[15:0];
               CSR_BLEND_KEEP: blend_keep_ff <= csr_wdata[KEEP_W-1:0];
               default: ;
            endcase
         end
         if (accept) begin
            prev_x_ff <= req_bus.accel_x;
            prev_y_ff <= req_bus.accel_y;
            prev_z_ff <= req_bus.accel_z;
         end
      end
      moved_ff <= moved_in;
      corr_ff  <= corr_in;
      if (load_out) begin
         roll_out_ff  <= roll_w;
         pitch_out_ff <= pitch_w;
         flags_out_ff <= {corr_ff, moved_ff};
      end
   end

   always_comb begin
      state_in     = state_ff;
      moved_in     = moved_ff;
      corr_in      = corr_ff;
      accept       = 1'b0;
      load_out     = 1'b0;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      unique case (state_ff)
         T_IDLE: begin
            accept = req_bus.valid;
            if (req_bus.valid) begin
               moved_in = {dz > 17'(change_thr_ff), dy > 17'(change_thr_ff),
                           dx > 17'(change_thr_ff)};
               corr_in  = dsum > gate_thr_ff;
               state_in = T_RUN;
            end
         end
         T_RUN: begin
            // wait for both axes and a free output word
            if (!roll_busy && !pitch_busy && (!out_valid_ff || rsp_bus.ready)) begin
               load_out     = 1'b1;
               out_valid_in = 1'b1;
               state_in     = T_IDLE;
            end
         end
         default: state_in = T_IDLE;
      endcase
   end

   assign axis_ctl       = '{start: accept, corr: corr_in};
   assign req_bus.ready  = (state_ff == T_IDLE);

   ctf_axis #(.CORDIC_STEPS(CORDIC_STEPS)) u_roll (
      .clock (clock),
      .reset (reset),
      .ctl   (axis_ctl),
      .rate  (req_bus.rate_x),
      .num   (req_bus.accel_x),
      .den   (req_bus.accel_z),
      .gain  (gyro_gain_ff),
      .keep  (keep_eff),
      .busy  (roll_busy),
      .angle (roll_w)
   );

   ctf_axis #(.CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
      .clock (clock),
      .reset (reset),
      .ctl   (axis_ctl),
      .rate  (req_bus.rate_y),
      .num   (req_bus.accel_y),
      .den   (req_bus.accel_z),
      .gain  (gyro_gain_ff),
      .keep  (keep_eff),
      .busy  (pitch_busy),
      .angle (pitch_w)
   );

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.roll_angle  = roll_out_ff;
   assign rsp_bus.pitch_angle = pitch_out_ff;
   assign rsp_bus.moved_x     = flags_out_ff[0];
   assign rsp_bus.moved_y     = flags_out_ff[1];
   assign rsp_bus.moved_z     = flags_out_ff[2];
   assign rsp_bus.corrected   = flags_out_ff[3];

endmodule

// ===== sv/ctf_axis.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ctf_axis
// one tilt axis: bit-serial gyro integration, iterative cordic atan2 and
// bit-serial blend of the two angles
// ---------------------------------------------------------------------------
module ctf_axis #(
   parameter int unsigned CORDIC_STEPS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ctf_pkg::ctf_axis_ctl_type   ctl,
   input  logic signed [15:0]          rate,
   input  logic signed [15:0]          num,
   input  logic signed [15:0]          den,
   input  logic [15:0]                 gain,
   input  logic [ctf_pkg::KEEP_W-1:0]  keep,
   output logic                        busy,
   output logic signed [31:0]          angle
);
   import ctf_pkg::*;

   localparam int unsigned STEPS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
   localparam logic [4:0] LAST_STEP = 5'(STEPS - 1);
   localparam logic [4:0] LAST_BIT  = 5'(KEEP_W - 1);

   ctf_ax_state_type          state_ff, state_in;
   logic signed [31:0]        angle_ff, angle_in;
   logic signed [ACC_W-1:0]   prod_ff, prod_in;
   logic signed [MCAND_W-1:0] mcand_ff, mcand_in;
   logic [KEEP_W-1:0]         mplier_ff, mplier_in;
   logic [4:0]                cnt_ff, cnt_in;
   logic signed [CRD_W-1:0]   x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic                      corr_ff, corr_in, zero_ff, zero_in;

   logic signed [ACC_W-1:0]   prod_next, mix;
   logic signed [CRD_W-1:0]   sx, sy, dn, nm, tab;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= AX_IDLE;
         angle_ff <= '0;
      end else begin
         state_ff <= state_in;
         angle_ff <= angle_in;
      end
      prod_ff   <= prod_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      cnt_ff    <= cnt_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      z_ff      <= z_in;
      corr_ff   <= corr_in;
      zero_ff   <= zero_in;
   end

   // msb-first shift and add, one multiplier bit per cycle
   assign prod_next = (prod_ff <<< 1) +
                      (mplier_ff[cnt_ff] ? ACC_W'(mcand_ff) : ACC_W'(0));
   assign mix = prod_next + (ACC_W'(z_ff) <<< 16) + ACC_W'(32768);
   assign sx  = x_ff >>> cnt_ff;
   assign sy  = y_ff >>> cnt_ff;
   assign tab = CRD_W'(ctf_atan(cnt_ff));
   assign dn  = CRD_W'(den) <<< 8;
   assign nm  = CRD_W'(num) <<< 8;

   always_comb begin
      state_in  = state_ff;
      angle_in  = angle_ff;
      prod_in   = prod_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      z_in      = z_ff;
      corr_in   = corr_ff;
      zero_in   = zero_ff;
      unique case (state_ff)
         AX_IDLE: begin
            if (ctl.start) begin
               state_in  = AX_MUL_RATE;
               corr_in   = ctl.corr;
               zero_in   = (num == 16'sd0) && (den == 16'sd0);
               prod_in   = '0;
               mcand_in  = MCAND_W'(rate);
               mplier_in = {1'b0, gain};
               cnt_in    = LAST_BIT;
               if (den < 16'sd0) begin
                  x_in = -dn;
                  y_in = -nm;
                  z_in = (num >= 16'sd0) ? DEG180 : -DEG180;
               end else begin
                  x_in = dn;
                  y_in = nm;
                  z_in = '0;
               end
            end
         end
         AX_MUL_RATE: begin
            prod_in = prod_next;
            cnt_in  = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               angle_in = ctf_sat32(ACC_W'(angle_ff) + prod_next);
               if (!corr_ff) begin
                  state_in = AX_IDLE;
               end else if (zero_ff) begin
                  // both operands zero: accel angle is zero
                  z_in      = '0;
                  prod_in   = '0;
                  mcand_in  = MCAND_W'(angle_in);
                  mplier_in = keep;
                  cnt_in    = LAST_BIT;
                  state_in  = AX_MUL_BLEND;
               end else begin
                  cnt_in   = '0;
                  state_in = AX_CORDIC;
               end
            end
         end
         AX_CORDIC: begin
            if (y_ff > 0) begin
               x_in = x_ff + sy;
               y_in = y_ff - sx;
               z_in = z_ff + tab;
            end else begin
               x_in = x_ff - sy;
               y_in = y_ff + sx;
               z_in = z_ff - tab;
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == LAST_STEP) begin
               // blend as keep*(angle-acc) + acc*65536
               prod_in   = '0;
               mcand_in  = MCAND_W'(angle_ff) - MCAND_W'(z_in);
               mplier_in = keep;
               cnt_in    = LAST_BIT;
               state_in  = AX_MUL_BLEND;
            end
         end
         AX_MUL_BLEND: begin
            prod_in = prod_next;
            cnt_in  = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               angle_in = ctf_sat32(mix >>> 16);
               state_in = AX_IDLE;
            end
         end
         default: state_in = AX_IDLE;
      endcase
   end

   assign busy  = (state_ff != AX_IDLE);
   assign angle = angle_ff;

endmodule
